/* hw/rtl/biquad_peaking_eq_filter_macros.svh */
// Assertion macros shared by the biquad EQ checker.
`ifndef BIQUAD_PEAKING_EQ_FILTER_MACROS_SVH
`define BIQUAD_PEAKING_EQ_FILTER_MACROS_SVH

// Next-cycle implication, disabled while reset is held.
`define BQPEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define BQPEQ_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/bqpeq_pkg.sv */
// Shared constants for the biquad peaking EQ filter.
`timescale 1ns / 1ps

package bqpeq_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 18;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FF0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FF1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FF2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FB1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FB2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN = 3'd6;

endpackage

/* hw/rtl/biquad_peaking_eq_filter.sv */
// Biquad direct-form-I section with wet/dry mix, one shared multiplier.
//
// Input channel s_*: one signed sample and a block-end marker per item.
// Output channel m_*: one mixed, saturated sample per input item, with the
// block-end marker copied through.
// Config port: cfg_wr_en/cfg_index/cfg_data writes one Q-format coefficient
// per cycle; write only while the block is idle. Index 7 is ignored.
// Sequence: after an item is accepted the block steps a sequencer through
// seven products through the single multiplier and its product register,
// one rounding step for the filter value, one accumulate and one output
// step. The result appears in the same cycle as s_ready returns, so a new
// item is accepted only after the last one has left the sequencer.
// Stall: a finished result sits in the output register; a next item may be
// accepted and computed, and its final step waits until that register frees.
// Reset: synchronous, active low; clears taps, coefficients (dry gain = 1.0)
// and the output valid.
`timescale 1ns / 1ps

module biquad_peaking_eq_filter #(
    parameter int SAMPLE_WIDTH = bqpeq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = bqpeq_pkg::COEF_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]     s_sample_in,
    input  logic                               s_block_end_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]     m_sample_out,
    output logic                               m_block_end_out,
    input  logic                               cfg_wr_en,
    input  logic [bqpeq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [COEF_WIDTH-1:0]              cfg_data
);
    import bqpeq_pkg::*;

    localparam int FRAC_BITS = COEF_WIDTH - 4;
    localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W     = PROD_W + 3;
    localparam int SHR_W     = ACC_W - FRAC_BITS;
    localparam int UP_W      = SHR_W - SAMPLE_WIDTH + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_MUL3 = 4'd4;
    localparam logic [3:0] S_MUL4 = 4'd5;
    localparam logic [3:0] S_DRY  = 4'd6;
    localparam logic [3:0] S_FILT = 4'd7;
    localparam logic [3:0] S_WET  = 4'd8;
    localparam logic [3:0] S_WACC = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    localparam logic signed [ACC_W-1:0] RND_HALF =
        ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX =
        {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN =
        {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [COEF_WIDTH-1:0] DRY_RESET = COEF_WIDTH'(1) << FRAC_BITS;

    logic [3:0] state_reg, state_next;

    logic signed [COEF_WIDTH-1:0] ff0_reg, ff1_reg, ff2_reg, fb1_reg, fb2_reg;
    logic signed [COEF_WIDTH-1:0] wet_reg, dry_reg;

    logic signed [SAMPLE_WIDTH-1:0] x1_reg, x2_reg, f1_reg, f2_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg, f_reg;
    logic                           end_reg;

    logic signed [SAMPLE_WIDTH-1:0] mul_a;
    logic signed [COEF_WIDTH-1:0]   mul_b;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;

    logic signed [ACC_W-1:0]        acc_rnd;
    logic signed [SHR_W-1:0]        acc_shr;
    logic [UP_W-1:0]                acc_upper;
    logic signed [SAMPLE_WIDTH-1:0] acc_sat;

    logic                           m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_end_reg;
    logic                           s_accept;
    logic                           out_free;
    logic                           out_load;

    assign s_ready         = (state_reg == S_IDLE);
    assign s_accept        = s_valid && s_ready;
    assign out_free        = !m_valid_reg || m_ready;
    assign out_load        = (state_reg == S_OUT) && out_free;
    assign m_valid         = m_valid_reg;
    assign m_sample_out    = out_sample_reg;
    assign m_block_end_out = out_end_reg;

    // round half up, shift, saturate
    assign acc_rnd   = acc_reg + RND_HALF;
    assign acc_shr   = SHR_W'(acc_rnd >>> FRAC_BITS);
    assign acc_upper = acc_shr[SHR_W-1:SAMPLE_WIDTH-1];
    assign acc_sat   = ((acc_upper == '0) || (acc_upper == '1)) ?
                       acc_shr[SAMPLE_WIDTH-1:0] :
                       (acc_shr[SHR_W-1] ? SAT_MIN : SAT_MAX);

    assign prod_ext = ACC_W'(prod_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL0: begin
                mul_a = x_reg;
                mul_b = ff0_reg;
            end
            S_MUL1: begin
                mul_a = x1_reg;
                mul_b = ff1_reg;
            end
            S_MUL2: begin
                mul_a = x2_reg;
                mul_b = ff2_reg;
            end
            S_MUL3: begin
                mul_a = f1_reg;
                mul_b = fb1_reg;
            end
            S_MUL4: begin
                mul_a = f2_reg;
                mul_b = fb2_reg;
            end
            S_DRY: begin
                mul_a = x_reg;
                mul_b = dry_reg;
            end
            S_WET: begin
                mul_a = f_reg;
                mul_b = wet_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        acc_next = acc_reg;
        case (state_reg)
            S_MUL1:  acc_next = prod_ext;
            S_MUL2:  acc_next = acc_reg + prod_ext;
            S_MUL3:  acc_next = acc_reg + prod_ext;
            S_MUL4:  acc_next = acc_reg - prod_ext;
            S_DRY:   acc_next = acc_reg - prod_ext;
            S_FILT:  acc_next = prod_ext;
            S_WACC:  acc_next = acc_reg + prod_ext;
            default: acc_next = acc_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = s_accept ? S_MUL0 : S_IDLE;
            S_MUL0:  state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_MUL3;
            S_MUL3:  state_next = S_MUL4;
            S_MUL4:  state_next = S_DRY;
            S_DRY:   state_next = S_FILT;
            S_FILT:  state_next = S_WET;
            S_WET:   state_next = S_WACC;
            S_WACC:  state_next = S_OUT;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            x1_reg      <= '0;
            x2_reg      <= '0;
            f1_reg      <= '0;
            f2_reg      <= '0;
            ff0_reg     <= '0;
            ff1_reg     <= '0;
            ff2_reg     <= '0;
            fb1_reg     <= '0;
            fb2_reg     <= '0;
            wet_reg     <= '0;
            dry_reg     <= DRY_RESET;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
                x2_reg      <= x1_reg;
                x1_reg      <= x_reg;
                f2_reg      <= f1_reg;
                f1_reg      <= f_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_COEF_FF0: ff0_reg <= cfg_data;
                    CFG_COEF_FF1: ff1_reg <= cfg_data;
                    CFG_COEF_FF2: ff2_reg <= cfg_data;
                    CFG_COEF_FB1: fb1_reg <= cfg_data;
                    CFG_COEF_FB2: fb2_reg <= cfg_data;
                    CFG_WET_GAIN: wet_reg <= cfg_data;
                    CFG_DRY_GAIN: dry_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        if (s_accept) begin
            x_reg   <= s_sample_in;
            end_reg <= s_block_end_in;
        end
        if (state_reg == S_FILT) begin
            f_reg <= acc_sat;
        end
        if (out_load) begin
            out_sample_reg <= acc_sat;
            out_end_reg    <= end_reg;
        end
    end

endmodule

/* hw/rtl/bqpeq_checker.sv */
// Port-level checker for the biquad EQ filter, bound to the top level.
`timescale 1ns / 1ps
`include "biquad_peaking_eq_filter_macros.svh"

module bqpeq_checker #(
    parameter int SAMPLE_WIDTH = bqpeq_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic signed [SAMPLE_WIDTH-1:0] m_sample_out,
    input logic                           m_block_end_out
);
    import bqpeq_pkg::*;

    logic s_accept;
    logic m_stall;

    assign s_accept = s_valid && s_ready;
    assign m_stall  = m_valid && !m_ready;

    `BQPEQ_ASSERT_NEXT_ALWAYS(a_reset_clears_valid, aclk, !aresetn, !m_valid,
        "output valid after reset")

    `BQPEQ_ASSERT_NEXT(a_one_item_in_flight, aclk, aresetn, s_accept, !s_ready,
        "input ready right after an accepted item")

    `BQPEQ_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_accept, !$rose(m_valid),
        "result appeared one cycle after acceptance")

    `BQPEQ_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_stall,
        m_valid && $stable(m_sample_out) && $stable(m_block_end_out),
        "stalled result changed")

endmodule

bind biquad_peaking_eq_filter bqpeq_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_bqpeq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sample_out   (m_sample_out),
    .m_block_end_out(m_block_end_out)
);
